// File: rtl/core/assert_macros.svh
// Assertion macros shared by the array queue RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define AQ_ASSERT_HOLD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define AQ_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/aqvu_pkg.sv
// Package for the array queue with value update: codes, types and defaults.
// Used by aqvu_front, aqvu_back and array_queue_with_value_update.
package aqvu_pkg;

	localparam int DEPTH_DEF = 16;

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);

	// request modes as they arrive on the mode port
	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_DEQ = 2'd1;
	localparam logic [1:0] MODE_UPD = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_ENQ,
		OP_DEQ,
		OP_UPD
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] data;
		logic signed [31:0] match;
	} cmd_t;

	typedef struct packed {
		logic               done;
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic               popped_valid;
		logic signed [31:0] head_value;
		logic               is_empty;
		logic               is_full;
	} res_t;

endpackage

// File: rtl/core/array_queue_with_value_update.sv
// Top level of the array queue with value update: front end, command
// queue and back end. Depends on aqvu_pkg, aqvu_front and aqvu_back.
//
//  channel   handshake               payload
//  --------  ----------------------  ------------------------------------------
//  request   start & !busy           mode, data_value, match_value
//  result    done (one-cycle strobe) status, popped_value, popped_valid,
//                                    head_value, is_empty, is_full
//
// Sequence: an enqueue completes in the back end straight from idle, a dequeue
// does too when it empties the queue and otherwise passes through S_DEQ (the new
// head comes through the memory's registered read port), an update scans the
// entries from the head until a match or the tail, one read of the entry memory
// per cycle. The result strobe is registered and follows in the cycle after the
// back end's last cycle on the transaction.
// Reset: arst_n clears indices to zero, marks the queue empty and drops the
// command queue; the entry memory is not cleared.
// Stalls: busy rises only while the two-entry command queue is full; the
// receiver cannot stall, every result is a single-cycle strobe.
module array_queue_with_value_update import aqvu_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [31:0] data_value,
	input  logic signed [31:0] match_value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic               popped_valid,
	output logic signed [31:0] head_value,
	output logic               is_empty,
	output logic               is_full
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	res_t res;

	// accept and decode each transaction, buffer it for the back end
	aqvu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.data_value  (data_value),
		.match_value (match_value),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	// execute against the entry memory and register the result
	aqvu_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res       (res)
	);

	// break the result record out onto its ports
	assign done         = res.done;
	assign status       = res.status;
	assign popped_value = res.popped_value;
	assign popped_valid = res.popped_valid;
	assign head_value   = res.head_value;
	assign is_empty     = res.is_empty;
	assign is_full      = res.is_full;

endmodule

// File: rtl/core/aqvu_front.sv
// Front end of the array queue: accepts requests, decodes the mode and
// holds them in a short command queue. Depends on aqvu_pkg.
`include "assert_macros.svh"

module aqvu_front import aqvu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [31:0] data_value,
	input  logic signed [31:0] match_value,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	cmd_t             slot_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   count_q;
	logic             push;
	logic             pop;
	op_t              op_dec;

	always_comb begin
		unique case (mode)
			MODE_ENQ: op_dec = OP_ENQ;
			MODE_DEQ: op_dec = OP_DEQ;
			MODE_UPD: op_dec = OP_UPD;
			default:  op_dec = OP_NOP;
		endcase
	end

	assign busy      = (count_q == (CQ_AW+1)'(CQ_DEPTH));
	assign push      = start && !busy;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: op_dec, data: data_value, match: match_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_AW'(CQ_DEPTH-1)) ? '0 : wr_ptr_q + CQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_AW'(CQ_DEPTH-1)) ? '0 : rd_ptr_q + CQ_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (CQ_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (CQ_AW+1)'(1);
			end
		end
	end

	`AQ_ASSERT_HOLD(a_cq_bound, count_q <= (CQ_AW+1)'(CQ_DEPTH), "command queue overfilled")
	`AQ_ASSERT_NEXT(a_cq_grow, push && !pop, count_q == $past(count_q) + (CQ_AW+1)'(1), "push lost")
	`AQ_ASSERT_NEXT(a_cq_drain, pop && !push, count_q == $past(count_q) - (CQ_AW+1)'(1), "pop lost")

endmodule

// File: rtl/core/aqvu_back.sv
// Back end of the array queue: entry memory, head/tail indices, the
// update scan and the result register. Depends on aqvu_pkg.
`include "assert_macros.svh"

module aqvu_back import aqvu_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output res_t res
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH-1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEQ  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic signed [31:0] mem [DEPTH];

	logic [1:0]         state_q, state_d;
	logic [AW-1:0]      head_q, head_d;
	logic [AW-1:0]      tail_q, tail_d;
	logic               empty_q, empty_d;
	logic [AW-1:0]      scan_q, scan_d;
	logic               issued_q, issued_d;
	logic               cmp_vld_s1, cmp_vld_d;
	logic [AW-1:0]      cmp_addr_s1;
	logic signed [31:0] rd_data_s1;
	logic signed [31:0] hval_q, hval_d;
	logic signed [31:0] pval_q, pval_d;
	logic signed [31:0] cur_data_q, cur_data_d;
	logic signed [31:0] cur_match_q, cur_match_d;
	res_t               res_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               emit;
	logic [1:0]         emit_status;
	logic signed [31:0] emit_popped;
	logic               emit_pvalid;
	logic               full_now;

	assign full_now = !empty_q && (tail_q == LAST);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		empty_d     = empty_q;
		scan_d      = scan_q;
		issued_d    = issued_q;
		cmp_vld_d   = 1'b0;
		hval_d      = hval_q;
		pval_d      = pval_q;
		cur_data_d  = cur_data_q;
		cur_match_d = cur_match_q;
		cmd_pop     = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = cur_data_q;
		rd_en       = 1'b0;
		rd_addr     = scan_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_popped = '0;
		emit_pvalid = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_ENQ: begin
							emit = 1'b1;
							if (full_now) begin
								emit_status = ST_FULL;
							end else if (empty_q) begin
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = cmd.data;
								head_d  = '0;
								tail_d  = '0;
								empty_d = 1'b0;
								hval_d  = cmd.data;
							end else begin
								wr_en   = 1'b1;
								wr_addr = tail_q + AW'(1);
								wr_data = cmd.data;
								tail_d  = tail_q + AW'(1);
							end
						end
						OP_DEQ: begin
							if (empty_q) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else if (head_q == tail_q) begin
								emit        = 1'b1;
								emit_popped = hval_q;
								emit_pvalid = 1'b1;
								head_d      = '0;
								tail_d      = '0;
								empty_d     = 1'b1;
							end else begin
								// fetch the next head from memory, finish next cycle
								pval_d  = hval_q;
								rd_en   = 1'b1;
								rd_addr = head_q + AW'(1);
								head_d  = head_q + AW'(1);
								state_d = S_DEQ;
							end
						end
						OP_UPD: begin
							if (empty_q) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								cur_data_d  = cmd.data;
								cur_match_d = cmd.match;
								scan_d      = head_q;
								issued_d    = 1'b0;
								state_d     = S_SCAN;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_DEQ: begin
				hval_d      = rd_data_s1;
				emit        = 1'b1;
				emit_popped = pval_q;
				emit_pvalid = 1'b1;
				state_d     = S_IDLE;
			end
			S_SCAN: begin
				if (cmp_vld_s1 && (rd_data_s1 == cur_match_q)) begin
					wr_en   = 1'b1;
					wr_addr = cmp_addr_s1;
					if (cmp_addr_s1 == head_q) begin
						hval_d = cur_data_q;
					end
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (cmp_vld_s1 && (cmp_addr_s1 == tail_q)) begin
					emit        = 1'b1;
					emit_status = ST_NOMATCH;
					state_d     = S_IDLE;
				end else if (!issued_q) begin
					rd_en     = 1'b1;
					rd_addr   = scan_q;
					cmp_vld_d = 1'b1;
					if (scan_q == tail_q) begin
						issued_d = 1'b1;
					end else begin
						scan_d = scan_q + AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			empty_q    <= 1'b1;
			scan_q     <= '0;
			issued_q   <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			res_q      <= '0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			empty_q    <= empty_d;
			scan_q     <= scan_d;
			issued_q   <= issued_d;
			cmp_vld_s1 <= cmp_vld_d;
			res_q.done <= emit;
			if (emit) begin
				res_q.status       <= emit_status;
				res_q.popped_value <= emit_popped;
				res_q.popped_valid <= emit_pvalid;
				res_q.head_value   <= empty_d ? 32'sd0 : hval_d;
				res_q.is_empty     <= empty_d;
				res_q.is_full      <= !empty_d && (tail_d == LAST);
			end
		end
	end

	always_ff @(posedge clk) begin
		hval_q      <= hval_d;
		pval_q      <= pval_d;
		cur_data_q  <= cur_data_d;
		cur_match_q <= cur_match_d;
		if (rd_en) begin
			cmp_addr_s1 <= rd_addr;
		end
	end

	assign res = res_q;

	`AQ_ASSERT_HOLD(a_empty_idx, !empty_q || (head_q == '0 && tail_q == '0), "empty with indices")
	`AQ_ASSERT_HOLD(a_head_le_tail, empty_q || (head_q <= tail_q), "head passed tail")
	`AQ_ASSERT_HOLD(a_pop_ok, !(res_q.done && res_q.popped_valid) || (res_q.status == ST_OK), "pop bad status")
	`AQ_ASSERT_HOLD(a_flags, !(res_q.done && res_q.is_full && res_q.is_empty), "full and empty")
	`AQ_ASSERT_NEXT(a_busy_no_pop, state_q != S_IDLE, !$past(cmd_pop), "pop while working")

endmodule

// File: verif/queue_result_checker.sv
// Result checker for array_queue_with_value_update: mirrors the queue contents,
// predicts each reply and compares it against the DUT result strobe.
// Depends on aqvu_pkg for the mode and status codes.
`timescale 1ns / 100ps

module queue_result_checker import aqvu_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [31:0] data_value,
	input  logic signed [31:0] match_value,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic signed [31:0] popped_value,
	input  logic               popped_valid,
	input  logic signed [31:0] head_value,
	input  logic               is_empty,
	input  logic               is_full,
	output int                 outstanding,
	output int                 mismatches
);

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic               popped_valid;
		logic signed [31:0] head_value;
		logic               is_empty;
		logic               is_full;
	} queue_reply_t;

	// shadow copy of the queue
	logic signed [31:0] shadow_slots [DEPTH];
	int unsigned        head_slot;
	int unsigned        tail_slot;
	logic               shadow_empty;

	queue_reply_t replies_due [$];
	queue_reply_t want;
	int           faults;
	logic         took;

	function automatic logic shadow_full();
		return !shadow_empty && tail_slot >= DEPTH - 1;
	endfunction

	// Apply one request to the shadow queue and return the reply it yields.
	function automatic queue_reply_t apply_request(logic [1:0] m, logic signed [31:0] d,
			logic signed [31:0] mv);
		queue_reply_t r;
		r.status       = ST_OK;
		r.popped_value = '0;
		r.popped_valid = 1'b0;
		case (m)
		MODE_ENQ: begin
			if (shadow_full()) begin
				r.status = ST_FULL;
			end else if (shadow_empty) begin
				head_slot       = 0;
				tail_slot       = 0;
				shadow_slots[0] = d;
				shadow_empty    = 1'b0;
			end else if (tail_slot + 1 < DEPTH) begin
				tail_slot               = tail_slot + 1;
				shadow_slots[tail_slot] = d;
			end else begin
				r.status = ST_FULL;
			end
		end
		MODE_DEQ: begin
			if (shadow_empty) begin
				r.status = ST_EMPTY;
			end else begin
				r.popped_value = shadow_slots[head_slot];
				r.popped_valid = 1'b1;
				if (head_slot >= tail_slot) begin
					head_slot    = 0;
					tail_slot    = 0;
					shadow_empty = 1'b1;
				end else begin
					head_slot = head_slot + 1;
				end
			end
		end
		MODE_UPD: begin
			if (shadow_empty) begin
				r.status = ST_EMPTY;
			end else begin
				// replace the first hit only, scanning from the head
				r.status = ST_NOMATCH;
				for (int unsigned i = head_slot; i <= tail_slot; i++) begin
					if (shadow_slots[i] == mv) begin
						shadow_slots[i] = d;
						r.status        = ST_OK;
						break;
					end
				end
			end
		end
		default: ;
		endcase
		r.head_value = shadow_empty ? '0 : shadow_slots[head_slot];
		r.is_empty   = shadow_empty;
		r.is_full    = shadow_full();
		return r;
	endfunction

	function automatic int field_differs(string name, logic signed [63:0] expected_val,
			logic signed [63:0] actual_val);
		if (actual_val !== expected_val) begin
			$error("%s: expected %0d, got %0d", name, expected_val, actual_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot    = 0;
			tail_slot    = 0;
			shadow_empty = 1'b1;
			replies_due.delete();
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			faults = 0;
			took   = start && !busy;
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("result transaction with no request outstanding");
					faults++;
				end else begin
					want = replies_due.pop_front();
					faults += field_differs("status", want.status, status);
					faults += field_differs("popped_value", want.popped_value, popped_value);
					faults += field_differs("popped_valid", want.popped_valid, popped_valid);
					faults += field_differs("head_value", want.head_value, head_value);
					faults += field_differs("is_empty", want.is_empty, is_empty);
					faults += field_differs("is_full", want.is_full, is_full);
				end
			end
			if (took)
				replies_due.push_back(apply_request(mode, data_value, match_value));
			outstanding <= replies_due.size();
			mismatches  <= mismatches + faults;
		end
	end

endmodule

// File: verif/testbench.sv
// Top of the array queue testbench: clock, reset, request stimulus and verdict.
// Depends on aqvu_pkg, array_queue_with_value_update and queue_result_checker.
`timescale 1ns / 100ps

module testbench;
	import aqvu_pkg::*;

	// mode value the block must ignore
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASE_ITEMS    = 163;
	localparam int SWEEP_LEN      = 40;
	localparam int POOL_SIZE      = 24;

	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic [1:0]         mode        = MODE_ENQ;
	logic signed [31:0] data_value  = '0;
	logic signed [31:0] match_value = '0;

	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] popped_value;
	logic               popped_valid;
	logic signed [31:0] head_value;
	logic               is_empty;
	logic               is_full;

	int outstanding;
	int mismatches;
	int cycle_count = 0;

	// recently enqueued values, so update requests hit stored entries often
	logic signed [31:0] recent_values [$];

	array_queue_with_value_update DUT (
		.clk, .arst_n, .start, .busy, .mode, .data_value, .match_value,
		.done, .status, .popped_value, .popped_valid, .head_value, .is_empty, .is_full
	);

	queue_result_checker checker_i (
		.clk, .arst_n, .start, .busy, .mode, .data_value, .match_value,
		.done, .status, .popped_value, .popped_valid, .head_value, .is_empty, .is_full,
		.outstanding, .mismatches
	);

	always #2 clk = ~clk;

	// Watchdog: abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Drive one request transaction and hold it until the block takes it.
	// Returns at the edge that accepts it, so the next call can keep start high.
	task automatic send_request(input logic [1:0] m, input logic signed [31:0] d,
			input logic signed [31:0] mv);
		start       <= 1'b1;
		mode        <= m;
		data_value  <= d;
		match_value <= mv;
		if (m == MODE_ENQ) begin
			recent_values.push_back(d);
			if (recent_values.size() > POOL_SIZE)
				void'(recent_values.pop_front());
		end
		do @(posedge clk); while (busy);
	endtask

	// Hold start low for as long as a random draw stays below idle_pct.
	task automatic idle_sender(input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Drop start and wait until every predicted result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Mostly full-range values, with a bias toward the extremes and repeats.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(7))
		0: begin
			case ($urandom_range(4))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'(signed'($urandom_range(3)));
			endcase
		end
		default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_match();
		if (recent_values.size() != 0 && $urandom_range(99) < 60)
			return recent_values[$urandom_range(recent_values.size() - 1)];
		return pick_value();
	endfunction

	initial begin
		int idle_pcts [4] = '{0, 71, 0, 6};
		int enq_pct;
		int pick;
		logic [1:0] m;

		// hold reset low, then release it on a rising edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: requests against the empty queue, including the spare mode
		send_request(MODE_DEQ, VAL_MAX, VAL_MIN);
		send_request(MODE_UPD, VAL_MIN, VAL_MIN);
		send_request(MODE_SPARE, VAL_MAX, VAL_MAX);

		// fill every slot, extremes first, so the tail reaches the last slot
		send_request(MODE_ENQ, VAL_MIN, '0);
		send_request(MODE_ENQ, VAL_MAX, '0);
		send_request(MODE_ENQ, 32'sd0, '0);
		send_request(MODE_ENQ, -32'sd1, '0);
		send_request(MODE_ENQ, -32'sd1, '0);
		send_request(MODE_ENQ, 32'sh5555_5555, '0);
		for (int i = 6; i < DEPTH_DEF; i++)
			send_request(MODE_ENQ, pick_value(), '0);

		// enqueue on a full queue is rejected
		send_request(MODE_ENQ, 32'sh1234_5678, '0);
		// update of a duplicated value touches the first copy only
		send_request(MODE_UPD, 32'shaaaa_aaaa, -32'sd1);
		// update with a value not stored
		send_request(MODE_UPD, VAL_MAX, 32'sh0bad_0bad);
		send_request(MODE_SPARE, '0, '0);
		// dequeue frees the head slot, but the queue still counts as full
		send_request(MODE_DEQ, '0, '0);
		send_request(MODE_ENQ, 32'sh0f0f_0f0f, '0);

		// pause until the directed part has fully drained
		drain_results();

		// Random: each phase sweeps between filling and draining the queue
		foreach (idle_pcts[p]) begin
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				enq_pct = ((k / SWEEP_LEN) % 2 == 0) ? 65 : 25;
				pick    = $urandom_range(99);
				if (pick < 3)
					m = MODE_SPARE;
				else if (pick < 23)
					m = MODE_UPD;
				else if (pick < 23 + enq_pct * 77 / 100)
					m = MODE_ENQ;
				else
					m = MODE_DEQ;
				idle_sender(idle_pcts[p]);
				send_request(m, pick_value(), pick_match());
			end
			// hold off the next phase until every result is back
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/aqvu_pkg.sv
rtl/core/aqvu_front.sv
rtl/core/aqvu_back.sv
rtl/core/array_queue_with_value_update.sv
verif/queue_result_checker.sv
verif/testbench.sv
